// ----- hdl/lsms_pkg.sv -----
// Shared types, codes and constants for the light sensor measurement sequencer.
// No dependencies; used by lsms_step and light_sensor_measure_sequencer_core.
package lsms_pkg;

  // event codes carried in op
  localparam logic [1:0] OP_TICK    = 2'd0;
  localparam logic [1:0] OP_POLL    = 2'd1;
  localparam logic [1:0] OP_TAKE    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  // measurement phases
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_WAIT = 2'd1;
  localparam logic [1:0] PH_READ = 2'd2;
  localparam logic [1:0] PH_DONE = 2'd3;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_LOW_RES     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONTINUOUS  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_RETRIES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_LOW    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAIT_HIGH   = 3'd4;
  localparam int unsigned CFG_DATA_W = 8;

  // field widths
  localparam int unsigned RAW_W   = 16;
  localparam int unsigned LUX_W   = 19;
  localparam int unsigned RETRY_W = 4;
  localparam int unsigned MS_W    = 8;

  // lux = floor(raw * scale / 3) done as raw * M >> 24, with M a little above scale * 2^24 / 3,
  // exact for every 16-bit raw value
  localparam int unsigned LUX_SHIFT = 24;
  localparam int unsigned LUX_MUL_W = 27;
  localparam int unsigned LUX_PROD_W = RAW_W + LUX_MUL_W;
  localparam logic [LUX_MUL_W-1:0] LUX_MUL_HIGH = 27'd55924060;
  localparam logic [LUX_MUL_W-1:0] LUX_MUL_LOW  = 27'd111848120;

  // lux*3 > 1200000 is the same as lux > 400000 (100000 lux, 2 fraction bits)
  localparam logic [LUX_W-1:0] LUX_LIMIT = 19'd400000;

  // configuration reset values
  localparam logic               RST_LOW_RES     = 1'b0;
  localparam logic               RST_CONTINUOUS  = 1'b1;
  localparam logic [RETRY_W-1:0] RST_MAX_RETRIES = 4'd3;
  localparam logic [MS_W-1:0]    RST_WAIT_LOW    = 8'd24;
  localparam logic [MS_W-1:0]    RST_WAIT_HIGH   = 8'd180;

  typedef struct packed {
    logic               low_res;
    logic               continuous;
    logic [RETRY_W-1:0] max_retries;
    logic [MS_W-1:0]    wait_low_ms;
    logic [MS_W-1:0]    wait_high_ms;
  } cfg_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic [MS_W-1:0]    elapsed;
    logic [RETRY_W-1:0] retry;
    logic               ready;
    logic [LUX_W-1:0]   lux;
  } state_t;

  typedef struct packed {
    logic [1:0]         phase;
    logic               data_ready;
    logic               take_ok;
    logic [LUX_W-1:0]   lux_value;
    logic [RETRY_W-1:0] retry_level;
  } result_t;

endpackage

// ----- hdl/lsms_step.sv -----
// Combinational step logic: next sequencer state and result for one event.
// Depends on lsms_pkg.
module lsms_step (
  input  lsms_pkg::cfg_t                 cfg,
  input  lsms_pkg::state_t               cur,
  input  logic [1:0]                     op,
  input  logic                           bus_ok,
  input  logic [lsms_pkg::RAW_W-1:0]     raw_sample,
  output lsms_pkg::state_t               nxt,
  output lsms_pkg::result_t              res
);

  logic [lsms_pkg::MS_W-1:0]       wait_ms;
  logic [lsms_pkg::LUX_MUL_W-1:0]  lux_mul;
  logic [lsms_pkg::LUX_PROD_W-1:0] product;
  logic [lsms_pkg::LUX_W-1:0]      conv;
  logic [lsms_pkg::RETRY_W-1:0]    retry_bump;
  logic                            took;
  logic [lsms_pkg::LUX_W-1:0]      lux_out;

  // conversion: one constant multiply, fraction bits dropped
  assign wait_ms = cfg.low_res ? cfg.wait_low_ms : cfg.wait_high_ms;
  assign lux_mul = cfg.low_res ? lsms_pkg::LUX_MUL_LOW : lsms_pkg::LUX_MUL_HIGH;
  assign product = lsms_pkg::LUX_PROD_W'(raw_sample) * lsms_pkg::LUX_PROD_W'(lux_mul);
  assign conv    = product[lsms_pkg::LUX_SHIFT +: lsms_pkg::LUX_W];

  // saturating retry increment
  assign retry_bump = (cur.retry == '1) ? cur.retry : cur.retry + 4'd1;

  // event handling
  always_comb begin
    nxt     = cur;
    took    = 1'b0;
    lux_out = '0;
    unique case (op)
      lsms_pkg::OP_TICK: begin
        if (cur.elapsed != '1) nxt.elapsed = cur.elapsed + 8'd1;
      end
      lsms_pkg::OP_POLL: begin
        if (cur.retry >= cfg.max_retries) begin
          // retry limit reached: give up
          nxt.phase = lsms_pkg::PH_IDLE;
          nxt.retry = '0;
          nxt.ready = 1'b0;
        end else begin
          unique case (cur.phase)
            lsms_pkg::PH_IDLE: begin
              nxt.phase = cur.phase;
            end
            lsms_pkg::PH_WAIT: begin
              if (cur.elapsed >= wait_ms) nxt.phase = lsms_pkg::PH_READ;
            end
            lsms_pkg::PH_READ: begin
              if (bus_ok) begin
                nxt.lux   = conv;
                nxt.ready = 1'b1;
                nxt.phase = lsms_pkg::PH_DONE;
                nxt.retry = '0;
              end else begin
                nxt.retry = retry_bump;
              end
            end
            lsms_pkg::PH_DONE: begin
              if (cur.lux > lsms_pkg::LUX_LIMIT) begin
                // out of range: discard and measure again
                nxt.retry   = retry_bump;
                nxt.phase   = lsms_pkg::PH_WAIT;
                nxt.elapsed = '0;
                nxt.ready   = 1'b0;
              end else if (!cur.ready) begin
                if (cfg.continuous) begin
                  nxt.phase   = lsms_pkg::PH_WAIT;
                  nxt.elapsed = '0;
                end else begin
                  nxt.phase = lsms_pkg::PH_IDLE;
                end
              end
            end
            default: nxt.phase = cur.phase;
          endcase
        end
      end
      lsms_pkg::OP_TAKE: begin
        if (cur.ready) begin
          took      = 1'b1;
          lux_out   = cur.lux;
          nxt.ready = 1'b0;
        end
      end
      lsms_pkg::OP_RESTART: begin
        if (bus_ok) begin
          nxt.phase   = lsms_pkg::PH_WAIT;
          nxt.elapsed = '0;
          nxt.ready   = 1'b0;
          nxt.retry   = '0;
        end else begin
          nxt.phase = lsms_pkg::PH_IDLE;
        end
      end
      default: nxt = cur;
    endcase
  end

  // result fields reflect the state after the step
  always_comb begin
    res.phase       = nxt.phase;
    res.data_ready  = nxt.ready;
    res.take_ok     = took;
    res.lux_value   = lux_out;
    res.retry_level = nxt.retry;
  end

endmodule

// ----- hdl/light_sensor_measure_sequencer_core.sv -----
// Top level of the light sensor measurement sequencer: ports, registers, handshakes.
// Depends on lsms_pkg and lsms_step.
//
// Each accepted event (tick, poll, host take, restart) yields exactly one result.
// One event is taken every clock cycle while the result side keeps up. An event
// waits in the input register until the result register can accept; then the state
// is updated and its result is loaded into the result register. The state update
// in lsms_step is combinational and includes the 16 x 27 bit constant multiply of
// the lux conversion. Configuration writes are always taken (cfg_ready is high)
// and act on the next event.
module light_sensor_measure_sequencer_core (
  input  logic                                clk,
  input  logic                                rst,
  // event channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [1:0]                          op,
  input  logic                                bus_ok,
  input  logic [lsms_pkg::RAW_W-1:0]          raw_sample,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          phase,
  output logic                                data_ready,
  output logic                                take_ok,
  output logic [lsms_pkg::LUX_W-1:0]          lux_value,
  output logic [lsms_pkg::RETRY_W-1:0]        retry_level,
  // configuration write channel
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lsms_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsms_pkg::CFG_DATA_W-1:0]     cfg_data
);

  lsms_pkg::cfg_t    cfg;
  lsms_pkg::state_t  st;
  lsms_pkg::state_t  st_next;
  lsms_pkg::result_t res;
  lsms_pkg::result_t res_reg;

  logic                          a_valid;
  logic [1:0]                    a_op;
  logic                          a_ok;
  logic [lsms_pkg::RAW_W-1:0]    a_raw;
  logic                          b_adv;
  logic                          a_adv;
  logic                          in_take;

  // handshake control
  assign b_adv    = !out_valid || !out_stall;
  assign a_adv    = a_valid && b_adv;
  assign in_stall = a_valid && !b_adv;
  assign in_take  = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.low_res      <= lsms_pkg::RST_LOW_RES;
      cfg.continuous   <= lsms_pkg::RST_CONTINUOUS;
      cfg.max_retries  <= lsms_pkg::RST_MAX_RETRIES;
      cfg.wait_low_ms  <= lsms_pkg::RST_WAIT_LOW;
      cfg.wait_high_ms <= lsms_pkg::RST_WAIT_HIGH;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsms_pkg::REG_LOW_RES:     cfg.low_res      <= cfg_data[0];
        lsms_pkg::REG_CONTINUOUS:  cfg.continuous   <= cfg_data[0];
        lsms_pkg::REG_MAX_RETRIES: cfg.max_retries  <= cfg_data[lsms_pkg::RETRY_W-1:0];
        lsms_pkg::REG_WAIT_LOW:    cfg.wait_low_ms  <= cfg_data;
        lsms_pkg::REG_WAIT_HIGH:   cfg.wait_high_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (in_take) begin
      a_valid <= 1'b1;
    end else if (a_adv) begin
      a_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      a_op  <= op;
      a_ok  <= bus_ok;
      a_raw <= raw_sample;
    end
  end

  // step logic
  lsms_step u_step (
    .cfg        (cfg),
    .cur        (st),
    .op         (a_op),
    .bus_ok     (a_ok),
    .raw_sample (a_raw),
    .nxt        (st_next),
    .res        (res)
  );

  // sequencer state, updated once per transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (a_adv) begin
      st <= st_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_adv) begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_adv) res_reg <= res;
  end

  assign phase       = res_reg.phase;
  assign data_ready  = res_reg.data_ready;
  assign take_ok     = res_reg.take_ok;
  assign lux_value   = res_reg.lux_value;
  assign retry_level = res_reg.retry_level;

  // checks
  a_take_clears_ready: assert property (@(posedge clk) disable iff (rst)
    (a_adv && a_op == lsms_pkg::OP_TAKE) |=> !st.ready)
    else $error("host take left data ready set");

  a_took_no_ready: assert property (@(posedge clk) disable iff (rst)
    (out_valid && take_ok) |-> !data_ready)
    else $error("result reports both a take and data still ready");

  a_lux_zero_no_take: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !take_ok) |-> (lux_value == '0))
    else $error("lux value nonzero without a take");

  a_held_input: assert property (@(posedge clk) disable iff (rst)
    (a_valid && !b_adv) |=> (a_valid && $stable(a_op) && $stable(a_raw)))
    else $error("input register changed while held");

  a_state_held: assert property (@(posedge clk) disable iff (rst)
    !a_adv |=> $stable(st))
    else $error("state changed without a transaction");

endmodule

// ----- tb/light_sensor_measure_sequencer_core_tb.sv -----
// Self-checking testbench for light_sensor_measure_sequencer_core.
// Holds its own model of the measurement sequence and compares every result with it.
// Depends on lsms_pkg and the RTL of the core; reads no file.
`timescale 1ns / 1ps

module light_sensor_measure_sequencer_core_tb;

  localparam int unsigned HIGH_RES_SCALE = 10;
  localparam int unsigned LOW_RES_SCALE  = 20;
  localparam int unsigned LONG_HOLD      = 64;
  localparam int unsigned END_CYCLES     = 10;
  localparam int unsigned MAX_CYCLES     = 100000;

  // Model of the sequencer: registers, measurement state and awaited results
  class measure_tracker;
    logic                         low_res;
    logic                         continuous;
    logic [lsms_pkg::RETRY_W-1:0] max_retries;
    logic [lsms_pkg::MS_W-1:0]    wait_low_ms;
    logic [lsms_pkg::MS_W-1:0]    wait_high_ms;
    logic [1:0]                   phase_q;
    logic [lsms_pkg::MS_W-1:0]    elapsed;
    logic [lsms_pkg::RETRY_W-1:0] retry;
    logic                         ready;
    logic [lsms_pkg::LUX_W-1:0]   lux;
    lsms_pkg::result_t            awaited_results[$];
    int                           mismatch_count;

    function new();
      low_res        = lsms_pkg::RST_LOW_RES;
      continuous     = lsms_pkg::RST_CONTINUOUS;
      max_retries    = lsms_pkg::RST_MAX_RETRIES;
      wait_low_ms    = lsms_pkg::RST_WAIT_LOW;
      wait_high_ms   = lsms_pkg::RST_WAIT_HIGH;
      phase_q        = lsms_pkg::PH_IDLE;
      elapsed        = '0;
      retry          = '0;
      ready          = 1'b0;
      lux            = '0;
      mismatch_count = 0;
    endfunction

    function void write_reg(logic [lsms_pkg::CFG_IDX_W-1:0] idx,
                            logic [lsms_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        lsms_pkg::REG_LOW_RES:     low_res = data[0];
        lsms_pkg::REG_CONTINUOUS:  continuous = data[0];
        lsms_pkg::REG_MAX_RETRIES: max_retries = data[lsms_pkg::RETRY_W-1:0];
        lsms_pkg::REG_WAIT_LOW:    wait_low_ms = data;
        lsms_pkg::REG_WAIT_HIGH:   wait_high_ms = data;
        default: ;
      endcase
    endfunction

    function void bump_retry();
      if (retry != 4'hF) retry++;
    endfunction

    function void poll(logic ok, logic [lsms_pkg::RAW_W-1:0] raw);
      int unsigned scaled;
      // retry limit overrides everything else
      if (retry >= max_retries) begin
        phase_q = lsms_pkg::PH_IDLE;
        retry   = '0;
        ready   = 1'b0;
        return;
      end
      case (phase_q)
        lsms_pkg::PH_WAIT: begin
          if (elapsed >= (low_res ? wait_low_ms : wait_high_ms))
            phase_q = lsms_pkg::PH_READ;
        end
        lsms_pkg::PH_READ: begin
          if (ok) begin
            scaled  = int'(raw) * (low_res ? LOW_RES_SCALE : HIGH_RES_SCALE);
            lux     = lsms_pkg::LUX_W'(scaled / 3);
            ready   = 1'b1;
            phase_q = lsms_pkg::PH_DONE;
            retry   = '0;
          end else begin
            bump_retry();
          end
        end
        lsms_pkg::PH_DONE: begin
          if (lux > lsms_pkg::LUX_LIMIT) begin
            // implausible reading: discard and convert again
            bump_retry();
            phase_q = lsms_pkg::PH_WAIT;
            elapsed = '0;
            ready   = 1'b0;
          end else if (!ready) begin
            if (continuous) begin
              phase_q = lsms_pkg::PH_WAIT;
              elapsed = '0;
            end else begin
              phase_q = lsms_pkg::PH_IDLE;
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void accept_event(logic [1:0] code, logic ok, logic [lsms_pkg::RAW_W-1:0] raw);
      lsms_pkg::result_t r;
      r = '0;
      case (code)
        lsms_pkg::OP_TICK: if (elapsed != 8'hFF) elapsed++;
        lsms_pkg::OP_POLL: poll(ok, raw);
        lsms_pkg::OP_TAKE: begin
          if (ready) begin
            r.take_ok   = 1'b1;
            r.lux_value = lux;
            ready       = 1'b0;
          end
        end
        default: begin
          if (ok) begin
            phase_q = lsms_pkg::PH_WAIT;
            elapsed = '0;
            ready   = 1'b0;
            retry   = '0;
          end else begin
            phase_q = lsms_pkg::PH_IDLE;
          end
        end
      endcase
      r.phase       = phase_q;
      r.data_ready  = ready;
      r.retry_level = retry;
      awaited_results.push_back(r);
    endfunction

    function void compare_result(lsms_pkg::result_t got);
      lsms_pkg::result_t want;
      if (awaited_results.size() == 0) begin
        $error("result transaction with nothing awaited");
        mismatch_count++;
        return;
      end
      want = awaited_results.pop_front();
      if (got.phase !== want.phase) begin
        $error("phase: expected %0d, got %0d", want.phase, got.phase);
        mismatch_count++;
      end
      if (got.data_ready !== want.data_ready) begin
        $error("data_ready: expected %0d, got %0d", want.data_ready, got.data_ready);
        mismatch_count++;
      end
      if (got.take_ok !== want.take_ok) begin
        $error("take_ok: expected %0d, got %0d", want.take_ok, got.take_ok);
        mismatch_count++;
      end
      if (got.lux_value !== want.lux_value) begin
        $error("lux_value: expected %0d, got %0d", want.lux_value, got.lux_value);
        mismatch_count++;
      end
      if (got.retry_level !== want.retry_level) begin
        $error("retry_level: expected %0d, got %0d", want.retry_level, got.retry_level);
        mismatch_count++;
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_stall;
  logic [1:0]                      op = lsms_pkg::OP_TICK;
  logic                            bus_ok = 1'b0;
  logic [lsms_pkg::RAW_W-1:0]      raw_sample = '0;
  logic                            out_valid;
  logic                            out_stall = 1'b0;
  logic [1:0]                      phase;
  logic                            data_ready;
  logic                            take_ok;
  logic [lsms_pkg::LUX_W-1:0]      lux_value;
  logic [lsms_pkg::RETRY_W-1:0]    retry_level;
  logic                            cfg_valid = 1'b0;
  logic                            cfg_ready;
  logic [lsms_pkg::CFG_IDX_W-1:0]  cfg_index = lsms_pkg::REG_LOW_RES;
  logic [lsms_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  measure_tracker tracker = new();
  bit          idling_on = 1'b1;
  bit          long_hold_req = 1'b0;
  int unsigned stall_left = 0;
  int unsigned cycle_count = 0;
  int unsigned bus_fail_pct = 20;

  light_sensor_measure_sequencer_core u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .op          (op),
    .bus_ok      (bus_ok),
    .raw_sample  (raw_sample),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .phase       (phase),
    .data_ready  (data_ready),
    .take_ok     (take_ok),
    .lux_value   (lux_value),
    .retry_level (retry_level),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == MAX_CYCLES) begin
      $display("status: fail");
      $finish;
    end
  end

  // Monitor: register writes and events feed the model, results are checked
  always @(posedge clk) begin
    lsms_pkg::result_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.write_reg(cfg_index, cfg_data);
      if (in_valid && !in_stall) tracker.accept_event(op, bus_ok, raw_sample);
      if (out_valid && !out_stall) begin
        got.phase       = phase;
        got.data_ready  = data_ready;
        got.take_ok     = take_ok;
        got.lux_value   = lux_value;
        got.retry_level = retry_level;
        tracker.compare_result(got);
      end
    end
  end

  // Result side: random stall bursts, plus one long hold on request
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      stall_left = LONG_HOLD;
    end else if (stall_left == 0 && idling_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4);
    end
    if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Offer one event; returns at the falling edge after its transaction
  task automatic send_event(logic [1:0] code, logic ok, logic [lsms_pkg::RAW_W-1:0] raw);
    in_valid   <= 1'b1;
    op         <= code;
    bus_ok     <= ok;
    raw_sample <= raw;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic sender_gap(int unsigned n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  // Stop offering until every awaited result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited_results.size() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(logic [lsms_pkg::CFG_IDX_W-1:0] idx,
                           logic [lsms_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic write_all_regs(logic lr, logic cont, logic [lsms_pkg::RETRY_W-1:0] retries,
                                logic [lsms_pkg::MS_W-1:0] wl,
                                logic [lsms_pkg::MS_W-1:0] wh);
    cfg_write(lsms_pkg::REG_LOW_RES, lsms_pkg::CFG_DATA_W'(lr));
    cfg_write(lsms_pkg::REG_CONTINUOUS, lsms_pkg::CFG_DATA_W'(cont));
    cfg_write(lsms_pkg::REG_MAX_RETRIES, lsms_pkg::CFG_DATA_W'(retries));
    cfg_write(lsms_pkg::REG_WAIT_LOW, wl);
    cfg_write(lsms_pkg::REG_WAIT_HIGH, wh);
  endtask

  function automatic logic [lsms_pkg::RAW_W-1:0] pick_raw();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 16'hFFFF;
      // at or over the lux limit at low res
      2: return lsms_pkg::RAW_W'($urandom_range(60000, 65535));
      default: return lsms_pkg::RAW_W'($urandom());
    endcase
  endfunction

  // Mostly follow the measurement sequence from the model's current phase,
  // with some noise events mixed in
  task automatic pick_event(output logic [1:0] code, output logic ok,
                            output logic [lsms_pkg::RAW_W-1:0] raw);
    logic [lsms_pkg::MS_W-1:0] conv_ms;
    conv_ms = tracker.low_res ? tracker.wait_low_ms : tracker.wait_high_ms;
    ok  = ($urandom_range(0, 99) >= bus_fail_pct);
    raw = pick_raw();
    if ($urandom_range(0, 9) == 0) begin
      code = 2'($urandom_range(0, 3));
      ok   = 1'($urandom());
    end else if ($urandom_range(0, 11) == 0) begin
      code = lsms_pkg::OP_TAKE;
    end else begin
      case (tracker.phase_q)
        lsms_pkg::PH_IDLE: code = lsms_pkg::OP_RESTART;
        lsms_pkg::PH_WAIT: begin
          if (tracker.elapsed < conv_ms)
            code = ($urandom_range(0, 9) == 0) ? lsms_pkg::OP_POLL : lsms_pkg::OP_TICK;
          else
            code = ($urandom_range(0, 3) == 0) ? lsms_pkg::OP_TICK : lsms_pkg::OP_POLL;
        end
        lsms_pkg::PH_READ: code = lsms_pkg::OP_POLL;
        default: code = (tracker.ready && $urandom_range(0, 1) == 0) ?
                        lsms_pkg::OP_TAKE : lsms_pkg::OP_POLL;
      endcase
    end
  endtask

  // Directed opening: extremes, every event and the corner cases
  task automatic run_directed();
    write_all_regs(1'b1, 1'b1, 4'd2, 8'd0, 8'd255);
    send_event(lsms_pkg::OP_POLL, 1'b1, 16'hFFFF);     // poll while idle
    send_event(lsms_pkg::OP_TAKE, 1'b0, 16'h0000);     // take with nothing ready
    send_event(lsms_pkg::OP_TICK, 1'b1, 16'h0000);
    send_event(lsms_pkg::OP_RESTART, 1'b0, 16'h0000);  // mode command not acknowledged
    send_event(lsms_pkg::OP_RESTART, 1'b1, 16'h0000);
    send_event(lsms_pkg::OP_POLL, 1'b0, 16'h0000);     // zero wait: straight to read
    send_event(lsms_pkg::OP_POLL, 1'b0, 16'h0000);     // bus error
    send_event(lsms_pkg::OP_POLL, 1'b1, 16'hFFFF);     // largest reading
    send_event(lsms_pkg::OP_TAKE, 1'b0, 16'h0000);
    send_event(lsms_pkg::OP_POLL, 1'b0, 16'h0000);     // over the lux limit
    send_event(lsms_pkg::OP_POLL, 1'b0, 16'h0000);
    send_event(lsms_pkg::OP_POLL, 1'b1, 16'h0000);     // zero reading
    send_event(lsms_pkg::OP_POLL, 1'b0, 16'h0000);     // not yet taken: stays
    send_event(lsms_pkg::OP_TAKE, 1'b1, 16'hFFFF);
    send_event(lsms_pkg::OP_TAKE, 1'b1, 16'hFFFF);     // second take finds nothing
    send_event(lsms_pkg::OP_POLL, 1'b1, 16'h0000);     // continuous restart
    send_event(lsms_pkg::OP_POLL, 1'b1, 16'h0000);
    send_event(lsms_pkg::OP_POLL, 1'b0, 16'h0000);
    send_event(lsms_pkg::OP_POLL, 1'b0, 16'h0000);
    send_event(lsms_pkg::OP_POLL, 1'b1, 16'hFFFF);     // retry limit reached
    send_event(lsms_pkg::OP_RESTART, 1'b1, 16'hFFFF);
    send_event(lsms_pkg::OP_TICK, 1'b0, 16'hFFFF);
    drain_results();
    // zero retry limit gives up on any poll
    write_all_regs(1'b0, 1'b0, 4'd0, 8'd255, 8'd2);
    send_event(lsms_pkg::OP_POLL, 1'b1, 16'h5555);
    drain_results();
    // one-shot high resolution measurement
    cfg_write(lsms_pkg::REG_MAX_RETRIES, lsms_pkg::CFG_DATA_W'(1));
    send_event(lsms_pkg::OP_RESTART, 1'b1, 16'hAAAA);
    send_event(lsms_pkg::OP_TICK, 1'b0, 16'h0000);
    send_event(lsms_pkg::OP_TICK, 1'b0, 16'h0000);
    send_event(lsms_pkg::OP_POLL, 1'b0, 16'h0000);
    send_event(lsms_pkg::OP_POLL, 1'b1, 16'hAAAA);
    send_event(lsms_pkg::OP_TAKE, 1'b0, 16'h0000);
    send_event(lsms_pkg::OP_POLL, 1'b0, 16'h0000);     // one-shot: back to idle
  endtask

  initial begin
    logic [1:0]                 code;
    logic                       ok;
    logic [lsms_pkg::RAW_W-1:0] raw;
    int unsigned                n_items;

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();

    // Random phases, each with its own register setting
    for (int p = 0; p < 6; p++) begin
      drain_results();
      write_all_regs(1'(p % 2), 1'(p == 2 || p == 3 || ($urandom_range(0, 1) == 0)),
                     (p == 0) ? 4'd15 : (p == 1) ? 4'd1 : 4'($urandom_range(1, 15)),
                     (p == 3) ? 8'd0 : 8'($urandom_range(0, 6)),
                     (p == 2) ? 8'd255 : (p == 3) ? 8'd0 : 8'($urandom_range(0, 6)));
      idling_on    = (p != 3) && (p != 5);
      bus_fail_pct = (p == 0) ? 60 : 20;
      n_items      = (p == 2) ? 350 : 110;
      for (int i = 0; i < n_items; i++) begin
        if (p == 1 && i == 30) long_hold_req = 1'b1;
        if (p == 4 && i == 50) drain_results();
        if (idling_on && $urandom_range(0, 4) == 0) sender_gap($urandom_range(1, 4));
        pick_event(code, ok, raw);
        send_event(code, ok, raw);
      end
    end

    drain_results();
    repeat (END_CYCLES) @(posedge clk);
    if (tracker.mismatch_count == 0 && tracker.awaited_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
